@@ hdl/bhpq_pkg.sv @@
// Shared types, constants and helpers of the binary heap priority queue.
package bhpq_pkg;

  localparam int unsigned DEF_CAPACITY = 256;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned NODE_W       = 8;
  localparam int unsigned OCC_W        = 9;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    MODE_MAX = 1'b0,
    MODE_MIN = 1'b1
  } mode_e;

  // register index is paddr[2]
  typedef enum logic {
    REG_ORDER_MODE = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_e;

  localparam mode_e ORDER_MODE_RST = MODE_MIN;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } entry_t;

  // true when key a must sit above key b
  function automatic logic goes_above(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b, mode_e mode);
    logic res;
    res = (mode == MODE_MIN) ? (a < b) : (a > b);
    return res;
  endfunction

endpackage

@@ hdl/bhpq_ifs.sv @@
// Valid/ready channel interfaces for heap commands and heap results.
interface bhpq_in_if import bhpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [KEY_W-1:0]  key;
  logic [NODE_W-1:0] edge_from;
  logic [NODE_W-1:0] edge_to;

  modport source (output valid, op, key, edge_from, edge_to, input ready);
  modport sink   (input valid, op, key, edge_from, edge_to, output ready);
endinterface

interface bhpq_out_if import bhpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [NODE_W-1:0]   out_from;
  logic [NODE_W-1:0]   out_to;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_key, out_from, out_to, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_from, out_to, occupancy, output ready);
endinterface

@@ hdl/binary_heap_priority_queue.sv @@
// Top level of the binary heap priority queue: config regs, sift sequencer, entry memory.
//
//  channel  | dir | handshake          | beat contents
//  ---------+-----+--------------------+------------------------------------------
//  in_ch    | in  | valid/ready        | op, key, edge_from, edge_to
//  out_ch   | out | valid/ready        | status, out_key, out_from, out_to, occupancy
//  apb      | in  | psel/penable/pready| order_mode at 0x0 (writable only when empty)
//
//  One item at a time. Insert reads the parent per level and moves it down while the
//  item goes above it; remove reads the top and last entries, then reads one or two
//  children per level and moves the better one up; error beats go straight to S_DONE.
//  The next beat is taken in S_IDLE, entered as the result is registered.
//  The single read port of the entry memory, with its registered read data,
//  sets the cost of every level of the sift.
//  Reset clears the count and sets min-heap mode; memory contents are left as is.
//  A finished result waits in the output register while the next beat is accepted;
//  the following result stalls in the sequencer until out_ch takes the first.
module binary_heap_priority_queue import bhpq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bhpq_in_if.sink               in_ch,
  bhpq_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  mode_e         order_mode;
  logic          heap_empty;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  bhpq_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .heap_empty_i (heap_empty),
    .order_mode_o (order_mode)
  );

  bhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (order_mode),
    .heap_empty_o (heap_empty),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  bhpq_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ hdl/bhpq_mem.sv @@
// Heap entry store: one write port, one read port, registered read data.
module bhpq_mem import bhpq_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [2**AW];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bhpq_cfg.sv @@
// APB register block holding the heap order mode.
module bhpq_cfg import bhpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  heap_empty_i,
  output mode_e                 order_mode_o
);

  mode_e mode_q;
  logic  wr_en;
  logic  sel_mode;

  assign sel_mode = (paddr[2] == REG_ORDER_MODE);
  assign wr_en    = psel && penable && pwrite && sel_mode;

  // mode only changes while the heap holds nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ORDER_MODE_RST;
    end else if (wr_en && heap_empty_i) begin
      mode_q <= mode_e'(pwdata[0]);
    end
  end

  assign pready       = 1'b1;
  assign prdata       = sel_mode ? {{(CFG_DATA_W-1){1'b0}}, mode_q} : '0;
  assign order_mode_o = mode_q;

endmodule

@@ hdl/bhpq_ctrl.sv @@
// Sift sequencer: walks the heap in memory for insert and remove, owns count and result beat.
module bhpq_ctrl import bhpq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned AW       = 8,
  parameter int unsigned CW       = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mode_e         mode_i,
  output logic          heap_empty_o,
  bhpq_in_if.sink       in_ch,
  bhpq_out_if.source    out_ch,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_RM_TOP, S_RM_LAST,
    S_DN_CHK, S_DN_C1, S_DN_C2, S_DONE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] hole_q;      // insert hole, 1-based
  logic [CW-1:0] par_q;       // sift-down hole, 1-based
  logic [CW:0]   child_q;     // sift-down child, 1-based
  entry_t        item_q;
  entry_t        top_q;
  entry_t        last_q;
  entry_t        best_q;
  status_e       res_status_q;
  entry_t        res_ent_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  entry_t              out_ent_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic          in_fire;
  logic          out_free;
  logic [CW-1:0] hole_m1;
  logic [CW-1:0] hole_par_m1;
  logic [CW-1:0] par_m1;
  logic [CW-1:0] cnt_m1;
  logic [CW:0]   child_m1;
  logic [CW:0]   cnt_ext;
  entry_t        cand;
  logic [CW:0]   cand_idx;
  logic          cand_moves;
  logic          ins_moves;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign heap_empty_o = (cnt_q == '0);

  assign hole_m1     = hole_q - CW'(1);
  assign hole_par_m1 = (hole_q >> 1) - CW'(1);
  assign par_m1      = par_q - CW'(1);
  assign cnt_m1      = cnt_q - CW'(1);
  assign child_m1    = child_q - (CW+1)'(1);
  assign cnt_ext     = {1'b0, cnt_q};
  assign ins_moves   = goes_above(item_q.key, mem_rdata_i.key, mode_i);

  // best child of the current level
  always_comb begin
    if (state_q == S_DN_C2 && goes_above(mem_rdata_i.key, best_q.key, mode_i)) begin
      cand     = mem_rdata_i;
      cand_idx = child_q + (CW+1)'(1);
    end else if (state_q == S_DN_C2) begin
      cand     = best_q;
      cand_idx = child_q;
    end else begin
      cand     = mem_rdata_i;
      cand_idx = child_q;
    end
    cand_moves = goes_above(cand.key, last_q.key, mode_i);
  end

  // memory port requests
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = item_q;
    mem_raddr_o = '0;
    unique case (state_q)
      S_INS_RD: begin
        if (hole_q > CW'(1)) begin
          mem_raddr_o = hole_par_m1[AW-1:0];
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = hole_m1[AW-1:0];
        end
      end
      S_INS_CMP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hole_m1[AW-1:0];
        mem_wdata_o = ins_moves ? mem_rdata_i : item_q;
      end
      S_RM_TOP: begin
        mem_raddr_o = cnt_m1[AW-1:0];
      end
      S_DN_CHK: begin
        if (child_q <= cnt_ext) begin
          mem_raddr_o = child_m1[AW-1:0];
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = par_m1[AW-1:0];
          mem_wdata_o = last_q;
        end
      end
      S_DN_C1: begin
        if (child_q < cnt_ext) begin
          mem_raddr_o = child_q[AW-1:0];
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = par_m1[AW-1:0];
          mem_wdata_o = cand_moves ? cand : last_q;
        end
      end
      S_DN_C2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = par_m1[AW-1:0];
        mem_wdata_o = cand_moves ? cand : last_q;
      end
      S_IDLE, S_RM_LAST, S_DONE: begin
        mem_raddr_o = '0;
      end
      default: begin
        mem_raddr_o = '0;
      end
    endcase
  end

  // sequencer, count and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      // result taken; a new one loaded in S_DONE replaces it
      if (out_valid_q && out_ch.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_ent_q <= '0;
            if (in_ch.op == OP_INSERT) begin
              if (cnt_q >= CW'(CAPACITY)) begin
                res_status_q <= ST_FULL;
                state_q      <= S_DONE;
              end else begin
                res_status_q <= ST_OK;
                item_q  <= '{key: in_ch.key, from_node: in_ch.edge_from,
                             to_node: in_ch.edge_to};
                hole_q  <= cnt_q + CW'(1);
                state_q <= S_INS_RD;
              end
            end else if (cnt_q == '0) begin
              res_status_q <= ST_EMPTY;
              state_q      <= S_DONE;
            end else begin
              res_status_q <= ST_OK;
              state_q      <= S_RM_TOP;
            end
          end
        end
        S_INS_RD: begin
          if (hole_q > CW'(1)) begin
            state_q <= S_INS_CMP;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_INS_CMP: begin
          if (ins_moves) begin
            hole_q  <= hole_q >> 1;
            state_q <= S_INS_RD;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_RM_TOP: begin
          top_q   <= mem_rdata_i;
          state_q <= S_RM_LAST;
        end
        S_RM_LAST: begin
          last_q  <= mem_rdata_i;
          cnt_q   <= cnt_m1;
          par_q   <= CW'(1);
          child_q <= (CW+1)'(2);
          state_q <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (child_q <= cnt_ext) begin
            state_q <= S_DN_C1;
          end else begin
            res_ent_q <= top_q;
            state_q   <= S_DONE;
          end
        end
        S_DN_C1, S_DN_C2: begin
          if (state_q == S_DN_C1 && child_q < cnt_ext) begin
            best_q  <= mem_rdata_i;
            state_q <= S_DN_C2;
          end else if (cand_moves) begin
            par_q   <= cand_idx[CW-1:0];
            child_q <= {cand_idx[CW-1:0], 1'b0};
            state_q <= S_DN_CHK;
          end else begin
            res_ent_q <= top_q;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_ent_q    <= res_ent_q;
            out_occ_q    <= OCC_W'(cnt_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.status    = out_status_q;
  assign out_ch.out_key   = out_ent_q.key;
  assign out_ch.out_from  = out_ent_q.from_node;
  assign out_ch.out_to    = out_ent_q.to_node;
  assign out_ch.occupancy = out_occ_q;

  // count stays within capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("heap count beyond capacity");

  // memory is never written while idle or holding a result
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we_o)
    else $error("memory write outside a sift");

  // remove on empty heap goes straight to the result with empty status
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_ch.op == OP_REMOVE && cnt_q == '0)
      |=> (state_q == S_DONE && res_status_q == ST_EMPTY))
    else $error("remove on empty heap not flagged");

  // count only moves while an item is in flight
  a_cnt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(cnt_q))
    else $error("count changed while idle");

endmodule
